FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int ADDR_BITS_DEF    = 24;

    localparam int          FIELD_BITS = 24;
    localparam int          GRAN_BYTES = 16;
    localparam logic [23:0] HEAP_RESET = 24'd65536;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_ZERO    = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

endpackage

FILE: hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing.
// Input channel (i_valid / o_stall) carries one request: i_req_type selects
// allocate (size in i_alloc_bytes) or free (usable offset in i_free_address).
// Output channel (o_valid / i_stall) returns one o_status per request.
// The block table lives in a single-port-read, single-port-write memory with
// a registered read port; one request is worked on at a time.
// A first-fit or address scan reads one entry per cycle; a split moves the
// tail up one entry per cycle and takes two more writes; a free with merge
// reads the next entry, then moves the tail down one entry per cycle. Scan
// position plus tail length never exceed the entry count. A zero-size
// allocate is answered straight from idle, with no table scan.
// The result stays in the output register until taken; a new request is
// accepted only once the result register is empty.
// Reset (synchronous, i_rst_n low) sets the heap to 65536 bytes and then
// writes the single free block in S_INIT. Writing i_cfg_wdata with i_cfg_we
// while idle sets the heap size and rebuilds the table the same way.
module first_fit_heap_allocator_top #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffha_pkg::ADDR_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ffha_pkg::FIELD_BITS-1:0]    i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_req_type,
    input  logic [ffha_pkg::FIELD_BITS-1:0]    i_alloc_bytes,
    input  logic [ffha_pkg::FIELD_BITS-1:0]    i_free_address,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status
);
    import ffha_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = IW + 1;
    localparam int AB = ADDR_BITS;
    localparam int SW = ((AB > FIELD_BITS) ? AB : FIELD_BITS) + 2;
    localparam logic [SW-1:0] AMASK = {{(SW-AB){1'b0}}, {AB{1'b1}}};
    localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] GRAN  = SW'(GRAN_BYTES);

    typedef struct packed {
        logic [AB-1:0] start;
        logic [AB-1:0] size;
        logic          free;
    } t_entry;

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_SCAN = 8'b0000_0100,
        S_SHU  = 8'b0000_1000,
        S_WSPL = 8'b0001_0000,
        S_WALC = 8'b0010_0000,
        S_FNXT = 8'b0100_0000,
        S_SHD  = 8'b1000_0000
    } t_state;

    t_entry mem [MAX_BLOCKS];
    t_entry r_rdata;

    t_state  r_state, n_state;
    logic [FIELD_BITS-1:0] r_heap, n_heap;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_j, n_j;
    logic [1:0]    r_k, n_k;
    logic          r_type, n_type;
    logic [SW-1:0] r_need, n_need;
    logic [SW-1:0] r_addr, n_addr;
    t_entry        r_blk, n_blk;
    t_entry        r_prev, n_prev;
    t_status       r_status, n_status;
    logic          r_out_valid, n_out_valid;

    logic [AW-1:0] raddr, waddr;
    logic          we;
    t_entry        wdata;

    logic          accept;
    logic [SW-1:0] total, cur_start, cur_size, nxt_size, merged;
    logic [SW-1:0] req_round;
    logic          hit, split, has_next, has_prev;
    logic [CW-1:0] d_idx;

    assign o_stall  = !(r_state == S_IDLE && !r_out_valid);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_status = r_status;

    assign total     = SW'(r_heap) & AMASK;
    assign cur_start = SW'(r_rdata.start);
    assign cur_size  = SW'(r_rdata.size);
    assign nxt_size  = SW'(r_rdata.size);
    assign req_round = (SW'(i_alloc_bytes) + (GRAN - SW'(1))) & ~(GRAN - SW'(1));

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_heap      = r_heap;
        n_count     = r_count;
        n_idx       = r_idx;
        n_j         = r_j;
        n_k         = r_k;
        n_type      = r_type;
        n_need      = r_need;
        n_addr      = r_addr;
        n_blk       = r_blk;
        n_prev      = r_prev;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        raddr       = '0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        hit         = 1'b0;
        split       = 1'b0;
        has_next    = 1'b0;
        has_prev    = 1'b0;
        merged      = '0;
        d_idx       = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                we          = 1'b1;
                waddr       = '0;
                wdata.start = '0;
                wdata.size  = (total > HDR) ? AB'(total - HDR) : '0;
                wdata.free  = 1'b1;
                n_count     = IW'(1);
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_type = i_req_type;
                    n_need = req_round;
                    n_addr = SW'(i_free_address);
                    if (i_req_type == REQ_ALLOC && i_alloc_bytes == '0) begin
                        n_status    = ST_ZERO;
                        n_out_valid = 1'b1;
                    end else begin
                        n_idx   = '0;
                        raddr   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_status    = (r_type == REQ_FREE) ? ST_BADFREE : ST_NOFIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    if (r_type == REQ_FREE) begin
                        hit = !r_rdata.free && (cur_start + HDR == r_addr);
                    end else begin
                        hit = r_rdata.free && (cur_size >= r_need);
                    end
                    // read ahead the next entry, unless a split must shift the tail first
                    raddr = AW'(r_idx + IW'(1));
                    if (!hit) begin
                        n_prev = r_rdata;
                        n_idx  = r_idx + IW'(1);
                    end else begin
                        n_blk = r_rdata;
                        if (r_type == REQ_FREE) begin
                            n_state = S_FNXT;
                        end else begin
                            split = (cur_size >= r_need + HDR + GRAN)
                                && (r_count < IW'(MAX_BLOCKS));
                            if (!split) begin
                                we          = 1'b1;
                                waddr       = AW'(r_idx);
                                wdata       = r_rdata;
                                wdata.free  = 1'b0;
                                n_status    = ST_OK;
                                n_out_valid = 1'b1;
                                n_state     = S_IDLE;
                            end else if (CW'(r_count) > CW'(r_idx) + CW'(1)) begin
                                n_j     = r_count;
                                raddr   = AW'(r_count - IW'(1));
                                n_state = S_SHU;
                            end else begin
                                n_state = S_WSPL;
                            end
                        end
                    end
                end
            end
            S_SHU: begin
                // move the tail up by one, last entry first
                we    = 1'b1;
                waddr = AW'(r_j);
                wdata = r_rdata;
                if (CW'(r_j) == CW'(r_idx) + CW'(2)) begin
                    n_state = S_WSPL;
                end else begin
                    n_j   = r_j - IW'(1);
                    raddr = AW'(r_j - IW'(2));
                end
            end
            S_WSPL: begin
                we          = 1'b1;
                waddr       = AW'(r_idx + IW'(1));
                wdata.start = AB'(SW'(r_blk.start) + HDR + r_need);
                wdata.size  = AB'(SW'(r_blk.size) - r_need - HDR);
                wdata.free  = 1'b1;
                n_state     = S_WALC;
            end
            S_WALC: begin
                we          = 1'b1;
                waddr       = AW'(r_idx);
                wdata.start = r_blk.start;
                wdata.size  = AB'(r_need);
                wdata.free  = 1'b0;
                n_count     = r_count + IW'(1);
                n_status    = ST_OK;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_FNXT: begin
                has_next = (CW'(r_idx) + CW'(1) < CW'(r_count)) && r_rdata.free;
                has_prev = (r_idx != '0) && r_prev.free;
                merged   = SW'(r_blk.size) + (has_next ? (HDR + nxt_size) : '0);
                we       = 1'b1;
                if (has_prev) begin
                    waddr       = AW'(r_idx - IW'(1));
                    wdata.start = r_prev.start;
                    wdata.size  = AB'(SW'(r_prev.size) + HDR + merged);
                    wdata.free  = 1'b1;
                    d_idx       = CW'(r_idx);
                    n_k         = has_next ? 2'd2 : 2'd1;
                end else begin
                    waddr       = AW'(r_idx);
                    wdata.start = r_blk.start;
                    wdata.size  = AB'(merged);
                    wdata.free  = 1'b1;
                    d_idx       = CW'(r_idx) + CW'(1);
                    n_k         = has_next ? 2'd1 : 2'd0;
                end
                if (n_k == 2'd0) begin
                    n_status    = ST_OK;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (d_idx + CW'(n_k) < CW'(r_count)) begin
                    n_j     = IW'(d_idx);
                    raddr   = AW'(d_idx + CW'(n_k));
                    n_state = S_SHD;
                end else begin
                    n_count     = r_count - IW'(n_k);
                    n_status    = ST_OK;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SHD: begin
                // close the gap, lowest entry first
                we    = 1'b1;
                waddr = AW'(r_j);
                wdata = r_rdata;
                if (CW'(r_j) + CW'(r_k) + CW'(1) >= CW'(r_count)) begin
                    n_count     = r_count - IW'(r_k);
                    n_status    = ST_OK;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_j   = r_j + IW'(1);
                    raddr = AW'(CW'(r_j) + CW'(r_k) + CW'(1));
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (i_cfg_we) begin
            n_heap  = i_cfg_wdata;
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_heap      <= HEAP_RESET;
            r_count     <= IW'(1);
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_heap      <= n_heap;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_j    <= n_j;
        r_k    <= n_k;
        r_type <= n_type;
        r_need <= n_need;
        r_addr <= n_addr;
        r_blk  <= n_blk;
        r_prev <= n_prev;
    end

endmodule

FILE: tb/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;

    import ffha_pkg::*;

class heap_scoreboard;
    localparam int NBLK = 64;
    localparam int HDR  = 32;

    logic [31:0] blk_start [NBLK];
    logic [31:0] blk_size  [NBLK];
    bit          blk_free  [NBLK];
    int          blk_count;
    logic [23:0] live_offsets [$];
    t_status     status_queue [$];
    int          errors;

    function new();
        errors = 0;
        rebuild(HEAP_RESET);
    endfunction

    function void rebuild(logic [23:0] heap);
        logic [31:0] total;
        total = {8'd0, heap};
        foreach (blk_start[k]) begin
            blk_start[k] = 0;
            blk_size[k]  = 0;
            blk_free[k]  = 0;
        end
        blk_size[0]  = (total > HDR) ? total - HDR : 0;
        blk_free[0]  = 1;
        blk_count    = 1;
        live_offsets.delete();
    endfunction

    function void drop_entry(int k);
        for (int j = k; j + 1 < blk_count; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_size[j]  = blk_size[j+1];
            blk_free[j]  = blk_free[j+1];
        end
        blk_count--;
    endfunction

    function t_status alloc_status(logic [23:0] req);
        logic [31:0] need;
        if (req == 0) return ST_ZERO;
        need = ({8'd0, req} + 32'd15) & ~32'd15;
        for (int i = 0; i < blk_count; i++) begin
            if (!blk_free[i] || blk_size[i] < need) continue;
            if (blk_size[i] >= need + HDR + 16 && blk_count < NBLK) begin
                for (int j = blk_count; j > i + 1; j--) begin
                    blk_start[j] = blk_start[j-1];
                    blk_size[j]  = blk_size[j-1];
                    blk_free[j]  = blk_free[j-1];
                end
                blk_start[i+1] = blk_start[i] + HDR + need;
                blk_size[i+1]  = blk_size[i] - need - HDR;
                blk_free[i+1]  = 1;
                blk_count++;
                blk_size[i] = need;
            end
            blk_free[i] = 0;
            live_offsets.push_back(24'(blk_start[i] + HDR));
            return ST_OK;
        end
        return ST_NOFIT;
    endfunction

    function t_status free_status(logic [23:0] addr);
        int i;
        for (i = 0; i < blk_count; i++)
            if (blk_start[i] + HDR == {8'd0, addr} && !blk_free[i]) break;
        if (i >= blk_count) return ST_BADFREE;
        foreach (live_offsets[k])
            if (live_offsets[k] == addr) begin
                live_offsets.delete(k);
                break;
            end
        blk_free[i] = 1;
        if (i + 1 < blk_count && blk_free[i+1]) begin
            blk_size[i] += HDR + blk_size[i+1];
            drop_entry(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
            blk_size[i-1] += HDR + blk_size[i];
            drop_entry(i);
        end
        return ST_OK;
    endfunction

    function void note_request(logic req_type, logic [23:0] bytes, logic [23:0] addr);
        if (req_type == REQ_FREE)
            status_queue.push_back(free_status(addr));
        else
            status_queue.push_back(alloc_status(bytes));
    endfunction

    function void check_result(logic [1:0] status);
        t_status want;
        if (status_queue.size() == 0) begin
            $display("%0t: unexpected result transfer, status %0d", $realtime, status);
            errors++;
            return;
        end
        want = status_queue.pop_front();
        if (status !== want) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, want, status);
            errors++;
        end
    endfunction

    function int pending();
        return status_queue.size();
    endfunction
endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [23:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [23:0] i_alloc_bytes;
    logic [23:0] i_free_address;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;

    heap_scoreboard heap_sb;
    int  idle_pct;
    int  sent_count;
    bit  hold_off_req;
    int  cycle_count;

    first_fit_heap_allocator_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_alloc_bytes  (i_alloc_bytes),
        .i_free_address (i_free_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 3000000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_req(logic req_type, logic [23:0] bytes, logic [23:0] addr);
        // idle gaps before the transfer
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid        <= 1;
        i_req_type     <= req_type;
        i_alloc_bytes  <= bytes;
        i_free_address <= addr;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        heap_sb.note_request(req_type, bytes, addr);
        sent_count++;
    endtask

    task automatic send_alloc(logic [23:0] bytes);
        send_req(REQ_ALLOC, bytes, 24'($urandom));
    endtask

    task automatic send_free(logic [23:0] addr);
        send_req(REQ_FREE, 24'($urandom), addr);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (heap_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_heap(logic [23:0] heap);
        i_cfg_we    <= 1;
        i_cfg_wdata <= heap;
        @(posedge i_clk);
        i_cfg_we <= 0;
        heap_sb.rebuild(heap);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic random_items(int count, int max_size);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (n == count / 3) idle_pct = 0;
            if (n == 2 * count / 3) idle_pct = 8;
            if (r < 3)
                send_alloc(0);
            else if (r < 8)
                send_alloc(24'($urandom));
            else if (r < 55)
                send_alloc(24'($urandom_range(1, max_size)));
            else if (r < 90 && heap_sb.live_offsets.size() != 0)
                send_free(heap_sb.live_offsets[
                    $urandom_range(heap_sb.live_offsets.size() - 1)]);
            else if (r < 95)
                send_free(24'($urandom));
            else
                send_free(24'({12'($urandom_range(0, 4095)), 4'h0}));
        end
    endtask

    // result side: check accepted results, stall at random or on a long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall   = 1;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) heap_sb.check_result(o_status);
            if (hold_off_req && hold_left == 0) begin
                hold_left    = 400;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1;
            end else begin
                i_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    initial begin
        logic [23:0] a0, a1, a2;
        heap_sb        = new();
        idle_pct       = 8;
        sent_count     = 0;
        hold_off_req   = 0;
        i_rst_n        = 0;
        i_cfg_we       = 0;
        i_cfg_wdata    = 0;
        i_valid        = 0;
        i_req_type     = REQ_ALLOC;
        i_alloc_bytes  = 0;
        i_free_address = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (3) @(posedge i_clk);

        // directed part on the reset heap
        send_alloc(0);
        send_alloc(24'hFFFFFF);
        send_alloc(1);
        send_alloc(16);
        send_alloc(17);
        send_free(24'hFFFFFF);
        send_free(0);
        drain();
        a0 = heap_sb.live_offsets[0];
        a1 = heap_sb.live_offsets[1];
        a2 = heap_sb.live_offsets[2];
        send_free(a1);
        send_free(a1);
        send_free(a0);
        send_free(a2);
        send_alloc(24'd65504);
        send_alloc(1);
        send_free(24'd32);
        send_alloc(24'd65488);
        drain();

        random_items(350, 400);
        hold_off_req = 1;
        random_items(50, 400);
        drain();

        write_heap(24'd1024);
        random_items(150, 120);
        drain();

        write_heap(24'hFFFFFF);
        random_items(250, 300000);
        drain();

        write_heap(24'd40);
        send_alloc(1);
        send_alloc(16);
        send_free(24'd32);
        random_items(15, 64);
        drain();

        write_heap(24'd0);
        send_alloc(1);
        send_free(24'd32);
        random_items(10, 64);
        drain();

        write_heap(24'd2048);
        random_items(200, 100);
        drain();

        write_heap(24'd65536);
        random_items(180, 2000);
        drain();

        repeat (150) @(posedge i_clk);
        if (heap_sb.errors == 0 && heap_sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
